@@ rtl/mlpd_pkg.sv @@
// shared types and constants for the marker/length packet deframer
// no dependencies; imported by every module of the block
`default_nettype none

package mlpd_pkg;

  // width of the config register index and data
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // packet layout: head(1) + verify(4) + seq(1) + cmd(1) + length(4) + tail(1)
  localparam int LEN_W       = 11;
  localparam int HDR_LEN     = 11;
  localparam int OVERHEAD    = HDR_LEN + 1;
  // hard cap on the total packet length, applied on top of max_packet_len
  localparam int MAX_PACKET  = 1024;
  localparam logic [LEN_W-1:0] MAX_PACKET_LEN_RST = LEN_W'(MAX_PACKET);

  // header byte positions, counted from the head byte at zero
  localparam logic [LEN_W-1:0] POS_SEQ     = LEN_W'(5);
  localparam logic [LEN_W-1:0] POS_CMD     = LEN_W'(6);
  localparam logic [LEN_W-1:0] POS_LEN_MSB = LEN_W'(10);

  // config register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAD_BYTE   = 2'd0,
    REG_VERIFY_WORD = 2'd1,
    REG_TAIL_BYTE   = 2'd2,
    REG_MAX_PKT_LEN = 2'd3
  } cfg_reg_t;

  // end status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_TAIL  = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  // live configuration seen by the deframer
  typedef struct packed {
    logic [7:0]       head_byte;
    logic [31:0]      verify_word;
    logic [7:0]       tail_byte;
    logic [LEN_W-1:0] max_packet_len;
  } cfg_t;

  // one result beat
  typedef struct packed {
    logic [1:0]       status;
    logic [LEN_W-1:0] packet_len;
    logic [7:0]       command;
    logic [7:0]       seq_number;
    logic [7:0]       payload_byte;
    logic             kind;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/mlpd_cfg_regs.sv @@
// configuration registers of the deframer, plain write port
// depends on mlpd_pkg
`default_nettype none

module mlpd_cfg_regs
  import mlpd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  // register write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.head_byte      <= '0;
      cfg.verify_word    <= '0;
      cfg.tail_byte      <= '0;
      cfg.max_packet_len <= MAX_PACKET_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HEAD_BYTE:   cfg.head_byte      <= cfg_wdata[7:0];
        REG_VERIFY_WORD: cfg.verify_word    <= cfg_wdata[31:0];
        REG_TAIL_BYTE:   cfg.tail_byte      <= cfg_wdata[7:0];
        REG_MAX_PKT_LEN: cfg.max_packet_len <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/mlpd_core.sv @@
// per-byte deframing state machine: hunt, verify, header, payload
// depends on mlpd_pkg; result is combinational from the current byte
`default_nettype none

module mlpd_core
  import mlpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic [7:0] rx_byte,
  input  cfg_t            cfg,
  output logic            res_valid,
  output result_t         res
);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_VERIFY  = 2'd1,
    PH_HEADER  = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  phase_t           phase, phase_next;
  logic [LEN_W-1:0] byte_count, byte_count_next;
  logic [7:0]       seq_hold, seq_hold_next;
  logic [7:0]       cmd_hold, cmd_hold_next;
  logic [23:0]      len_lo, len_lo_next;     // low three length bytes
  logic [LEN_W-1:0] total_len, total_len_next;

  logic [1:0]       vidx;
  logic [7:0]       want;
  logic [32:0]      total_wide;
  logic [15:0]      limit;
  logic             too_large;
  logic [LEN_W:0]   count_inc;

  // expected verify byte for this position
  assign vidx = byte_count[1:0] - 2'd1;
  always_comb begin
    case (vidx)
      2'd0:    want = cfg.verify_word[7:0];
      2'd1:    want = cfg.verify_word[15:8];
      2'd2:    want = cfg.verify_word[23:16];
      default: want = cfg.verify_word[31:24];
    endcase
  end

  // length check on the last length byte
  assign total_wide = {1'b0, rx_byte, len_lo} + 33'(OVERHEAD);
  assign limit      = ({5'd0, cfg.max_packet_len} > 16'(MAX_PACKET)) ?
                      16'(MAX_PACKET) : {5'd0, cfg.max_packet_len};
  assign too_large  = total_wide > {17'd0, limit};

  assign count_inc  = {1'b0, byte_count} + (LEN_W+1)'(1);

  // next state and result
  always_comb begin
    phase_next      = phase;
    byte_count_next = byte_count;
    seq_hold_next   = seq_hold;
    cmd_hold_next   = cmd_hold;
    len_lo_next     = len_lo;
    total_len_next  = total_len;
    res_valid       = 1'b0;
    res.kind         = KIND_PAYLOAD;
    res.payload_byte = '0;
    res.seq_number   = seq_hold;
    res.command      = cmd_hold;
    res.packet_len   = '0;
    res.status       = ST_OK;

    unique case (phase)
      PH_HUNT: begin
        if (rx_byte == cfg.head_byte) begin
          phase_next      = PH_VERIFY;
          byte_count_next = LEN_W'(1);
        end
      end

      PH_VERIFY: begin
        if (rx_byte == want) begin
          byte_count_next = count_inc[LEN_W-1:0];
          if (byte_count == LEN_W'(4)) phase_next = PH_HEADER;
        end else if (rx_byte == cfg.head_byte) begin
          byte_count_next = LEN_W'(1);
        end else begin
          phase_next      = PH_HUNT;
          byte_count_next = '0;
        end
      end

      PH_HEADER: begin
        byte_count_next = count_inc[LEN_W-1:0];
        if (byte_count == POS_SEQ) begin
          seq_hold_next = rx_byte;
        end else if (byte_count == POS_CMD) begin
          cmd_hold_next = rx_byte;
        end else if (byte_count == POS_LEN_MSB) begin
          // last length byte: check the whole packet against the limit
          if (too_large) begin
            res_valid       = 1'b1;
            res.kind        = KIND_END;
            res.status      = ST_TOO_LARGE;
            phase_next      = PH_HUNT;
            byte_count_next = '0;
          end else begin
            phase_next     = PH_PAYLOAD;
            total_len_next = total_wide[LEN_W-1:0];
          end
        end else begin
          case (byte_count[1:0])
            2'd3:    len_lo_next[7:0]   = rx_byte;  // position 7
            2'd0:    len_lo_next[15:8]  = rx_byte;  // position 8
            default: len_lo_next[23:16] = rx_byte;  // position 9
          endcase
        end
      end

      PH_PAYLOAD: begin
        res_valid = 1'b1;
        if (count_inc >= {1'b0, total_len}) begin
          // tail byte closes the packet
          res.kind        = KIND_END;
          res.packet_len  = total_len;
          res.status      = (rx_byte == cfg.tail_byte) ? ST_OK : ST_BAD_TAIL;
          phase_next      = PH_HUNT;
          byte_count_next = '0;
        end else begin
          res.payload_byte = rx_byte;
          byte_count_next  = count_inc[LEN_W-1:0];
        end
      end

      default: ;
    endcase

    // any end or error wipes the packet context
    if (phase_next == PH_HUNT) begin
      seq_hold_next  = '0;
      cmd_hold_next  = '0;
      len_lo_next    = '0;
      total_len_next = '0;
    end
  end

  // state registers, moved only on a processed beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      byte_count <= '0;
      seq_hold   <= '0;
      cmd_hold   <= '0;
      len_lo     <= '0;
      total_len  <= '0;
    end else if (fire) begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
      seq_hold   <= seq_hold_next;
      cmd_hold   <= cmd_hold_next;
      len_lo     <= len_lo_next;
      total_len  <= total_len_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/marker_length_packet_deframer_top.sv @@
// top level of the marker/length packet deframer
// depends on mlpd_pkg, mlpd_cfg_regs, mlpd_core
//
//  channel | dir | handshake         | content
//  --------+-----+-------------------+-----------------------------------------
//  s_*     | in  | s_tvalid/s_tready | one received byte per beat
//  m_*     | out | m_tvalid/m_tready | payload byte, or end/error with status
//  cfg_*   | in  | cfg_we            | register write, index and data
//
// one byte per cycle sustained while m_tready stays high; each byte waits in
// the input register and its result is registered in the output register.
// the input register takes a new byte while a result waits to be taken;
// a stall on m_tready holds the input register once it is full.
// rst is synchronous; it clears state and valid flags and resets the config.
`default_nettype none

module marker_length_packet_deframer_top
  import mlpd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [7:0]            s_tdata,   // [7:0] rx_byte
  // output stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [39:0]                m_tdata,   // [7:0] payload_byte, [15:8] seq_number,
                                                // [23:16] command, [34:24] packet_len,
                                                // [36:35] status, [39:37] zero
  output logic                       m_tuser,   // [0] kind
  // config write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t       cfg;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       proc;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  mlpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // input register advances when the output register has room
  assign proc     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  mlpd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (proc),
    .rx_byte   (in_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (proc && res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tuser = out_res.kind;
  assign m_tdata = {3'd0, out_res.status, out_res.packet_len, out_res.command,
                    out_res.seq_number, out_res.payload_byte};

  // an end beat never carries a payload byte
  a_end_no_payload: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.kind == KIND_END |-> out_res.payload_byte == 8'd0)
    else $error("end beat carries a payload byte");

  // a completed packet is at least as long as its framing
  a_end_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.kind == KIND_END && out_res.status != ST_TOO_LARGE
      |-> out_res.packet_len >= LEN_W'(OVERHEAD))
    else $error("packet end with length shorter than framing");

  // payload beats report neither length nor status
  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.kind == KIND_PAYLOAD
      |-> out_res.packet_len == '0 && out_res.status == ST_OK)
    else $error("payload beat with length or status set");

  // a processed byte frees the input register unless a new byte is taken in its place
  a_proc_frees: assert property (@(posedge clk) disable iff (rst)
    proc && !s_tvalid |=> !in_valid)
    else $error("input register still full after its byte was processed");

endmodule

`default_nettype wire
